// File: rtl/core/tks_pkg.sv
// Package for the top-k score selector: sizes, payload structs and cell control types.
// Used by tks_cell, top_k_score_selector_unit and the testbench; depends on nothing else.
package tks_pkg;

    localparam int MAX_KEEP = 16;
    localparam int KEEP_W   = 5;
    localparam int COUNT_W  = $clog2(MAX_KEEP + 1);
    localparam int WIDE_W   = (COUNT_W > KEEP_W) ? COUNT_W : KEEP_W;
    localparam int RANK_W   = 4;
    localparam int KEEP_RESET = 10;

    typedef struct packed {
        logic               mode;
        logic [31:0]        doc_id;
        logic signed [31:0] score;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        out_doc_id;
        logic signed [31:0] out_score;
        logic [RANK_W-1:0]  rank;
        logic               last;
        logic               empty_res;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        doc;
        logic signed [31:0] score;
    } entry_t;

    typedef struct packed {
        logic   insert;
        logic   shift;
        entry_t cand;
    } cell_ctrl_t;

endpackage

// File: rtl/core/tks_cell.sv
// One cell of the sorted chain: holds one entry and compares it with the candidate.
// Depends on tks_pkg for the entry and control types.
module tks_cell (
    input  logic                aclk,
    input  tks_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                left_ge,
    input  tks_pkg::entry_t     left_entry,
    input  tks_pkg::entry_t     right_entry,
    output logic                ge,
    output tks_pkg::entry_t     entry
);
    import tks_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign ge    = occupied && (entry_reg.score >= ctrl.cand.score);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (ctrl.insert && !ge) begin
            entry_next = left_ge ? ctrl.cand : left_entry;
        end else if (ctrl.shift) begin
            entry_next = right_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/core/top_k_score_selector_unit.sv
// Top level of the top-k score selector: control, count and the chain of cells.
// Depends on tks_pkg and tks_cell.
//
// The block keeps the best keep_count candidates (one if keep_count is zero, at most
// MAX_KEEP) in a chain of MAX_KEEP cells kept in descending score order; offers stream
// at one per cycle while the block is idle. A finish request drains the chain from its
// head at one result per cycle while m_ready is high, or gives one empty result if none
// is kept; meanwhile no input request is accepted. Ties keep arrival order.
module top_k_score_selector_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tks_pkg::in_item_t      s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tks_pkg::out_item_t     m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [tks_pkg::KEEP_W-1:0] cfg_data
);
    import tks_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [KEEP_W-1:0]  keep_reg;

    logic [COUNT_W-1:0] limit;
    logic               can_grow, any_lt, offer, finish, out_fire;
    cell_ctrl_t         ctrl;
    logic [MAX_KEEP-1:0] ge, occ;
    entry_t             cell_entry [MAX_KEEP];
    entry_t             left_entry [MAX_KEEP];
    entry_t             right_entry [MAX_KEEP];
    logic [MAX_KEEP-1:0] left_ge;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_DRAIN) || (state_reg == ST_EMPTY);
    assign out_fire  = m_valid && m_ready;
    assign offer     = s_valid && s_ready && !s_data.mode;
    assign finish    = s_valid && s_ready && s_data.mode;

    always_comb begin
        if (keep_reg == '0) begin
            limit = COUNT_W'(1);
        end else if (WIDE_W'(keep_reg) > WIDE_W'(MAX_KEEP)) begin
            limit = COUNT_W'(MAX_KEEP);
        end else begin
            limit = COUNT_W'(keep_reg);
        end
    end

    assign can_grow = (count_reg < limit);
    assign any_lt   = |(occ & ~ge);

    assign ctrl.cand.doc   = s_data.doc_id;
    assign ctrl.cand.score = s_data.score;
    assign ctrl.insert     = offer && (can_grow || ((count_reg != '0) && any_lt));
    assign ctrl.shift      = (state_reg == ST_DRAIN) && out_fire;

    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_chain
        assign occ[i] = (WIDE_W'(i) < WIDE_W'(count_reg));
        if (i == 0) begin : g_head
            assign left_ge[i]    = 1'b1;
            assign left_entry[i] = ctrl.cand;
        end else begin : g_body
            assign left_ge[i]    = ge[i-1];
            assign left_entry[i] = cell_entry[i-1];
        end
        if (i == MAX_KEEP - 1) begin : g_tail
            assign right_entry[i] = ctrl.cand;
        end else begin : g_inner
            assign right_entry[i] = cell_entry[i+1];
        end
        tks_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_ge     (left_ge[i]),
            .left_entry  (left_entry[i]),
            .right_entry (right_entry[i]),
            .ge          (ge[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.insert && can_grow) begin
                    count_next = count_reg + COUNT_W'(1);
                end
                if (finish) begin
                    rank_next  = '0;
                    state_next = (count_reg == '0) ? ST_EMPTY : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_fire) begin
                    count_next = count_reg - COUNT_W'(1);
                    rank_next  = rank_reg + RANK_W'(1);
                    if (count_reg == COUNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_DRAIN) begin
            m_data.out_doc_id = cell_entry[0].doc;
            m_data.out_score  = cell_entry[0].score;
            m_data.rank       = rank_reg;
            m_data.last       = (count_reg == COUNT_W'(1));
            m_data.empty_res  = 1'b0;
        end else begin
            m_data.out_doc_id = '0;
            m_data.out_score  = '0;
            m_data.rank       = '0;
            m_data.last       = 1'b0;
            m_data.empty_res  = (state_reg == ST_EMPTY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rank_reg  <= '0;
            keep_reg  <= KEEP_W'(KEEP_RESET);
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            if (cfg_valid && cfg_ready) begin
                keep_reg <= cfg_data;
            end
        end
    end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for top_k_score_selector_unit: directed and random candidate streams,
// finish requests and keep_count writes, with results checked against an in-bench ranking model.
// Depends on tks_pkg and the RTL of top_k_score_selector_unit.
module testbench;
    import tks_pkg::*;

    localparam logic MODE_OFFER  = 1'b0;
    localparam logic MODE_FINISH = 1'b1;
    localparam int   DRAIN_SLACK = 8;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [KEEP_W-1:0]  cfg_data;

    logic [31:0]        held_doc [MAX_KEEP];
    logic signed [31:0] held_score [MAX_KEEP];
    int                 held_len = 0;
    logic [KEEP_W-1:0]  keep_setting = KEEP_W'(KEEP_RESET);
    out_item_t          ranked_expect [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int request_count  = 0;
    int finish_count   = 0;
    int result_count   = 0;
    int keep_writes    = 0;

    top_k_score_selector_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void insert_ranked(logic [31:0] doc, logic signed [31:0] sc);
        int pos;
        pos = 0;
        while (pos < held_len && held_score[pos] >= sc) pos++;
        for (int i = held_len; i > pos; i--) begin
            held_doc[i]   = held_doc[i-1];
            held_score[i] = held_score[i-1];
        end
        held_doc[pos]   = doc;
        held_score[pos] = sc;
        held_len++;
    endfunction

    function automatic void predict_ranking(in_item_t req);
        int                 cap;
        logic signed [31:0] sc;
        out_item_t          res;
        cap = (keep_setting == 0) ? 1 : ((keep_setting > MAX_KEEP) ? MAX_KEEP : keep_setting);
        sc  = req.score;
        if (req.mode == MODE_OFFER) begin
            if (held_len < cap && held_len < MAX_KEEP) begin
                insert_ranked(req.doc_id, sc);
            end else if (held_len > 0 && sc > held_score[held_len-1]) begin
                held_len--;
                insert_ranked(req.doc_id, sc);
            end
        end else begin
            finish_count++;
            if (held_len == 0) begin
                res = '0;
                res.empty_res = 1'b1;
                ranked_expect = {ranked_expect, res};
            end else begin
                for (int i = 0; i < held_len; i++) begin
                    res.out_doc_id = held_doc[i];
                    res.out_score  = held_score[i];
                    res.rank       = RANK_W'(i);
                    res.last       = (i == held_len - 1);
                    res.empty_res  = 1'b0;
                    ranked_expect = {ranked_expect, res};
                end
            end
            held_len = 0;
        end
    endfunction

    // Configuration writes and input requests update the ranking model before the result
    // taken at the same edge is compared, so the outcome never depends on process order.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) keep_setting = cfg_data;
            if (s_valid && s_ready) begin
                predict_ranking(s_data);
                request_count++;
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (ranked_expect.size() == 0) begin
                    $error("unexpected result: doc %0h score %0h", m_data.out_doc_id,
                           m_data.out_score);
                    error_count++;
                end else begin
                    want = ranked_expect.pop_front();
                    if (m_data.out_doc_id !== want.out_doc_id) begin
                        $error("out_doc_id: expected %0h, got %0h", want.out_doc_id,
                               m_data.out_doc_id);
                        error_count++;
                    end
                    if (m_data.out_score !== want.out_score) begin
                        $error("out_score: expected %0h, got %0h", want.out_score,
                               m_data.out_score);
                        error_count++;
                    end
                    if (m_data.rank !== want.rank) begin
                        $error("rank: expected %0d, got %0d", want.rank, m_data.rank);
                        error_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_data.last);
                        error_count++;
                    end
                    if (m_data.empty_res !== want.empty_res) begin
                        $error("empty_res: expected %0b, got %0b", want.empty_res,
                               m_data.empty_res);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic send_request(input logic mode, input logic [31:0] doc,
                                input logic signed [31:0] sc);
        in_item_t req;
        req.mode   = mode;
        req.doc_id = doc;
        req.score  = sc;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ranked_expect.size() != 0) @(negedge aclk);
        repeat (DRAIN_SLACK) @(negedge aclk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        keep_writes++;
    endtask

    function automatic logic signed [31:0] random_score();
        int near;
        near = $urandom_range(0, 6);
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return near - 3;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KEEP_W-1:0] random_keep();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 31;
            2:       return KEEP_W'(MAX_KEEP);
            default: return KEEP_W'($urandom_range(1, 15));
        endcase
    endfunction

    task automatic run_random_queries(input int budget);
        int sent;
        int offers;
        sent = 0;
        while (sent < budget) begin
            offers = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 12);
            for (int i = 0; i < offers; i++) begin
                if ($urandom_range(0, 39) == 0) write_keep(random_keep());
                send_request(MODE_OFFER, $urandom(), random_score());
            end
            send_request(MODE_FINISH, $urandom(), random_score());
            sent += offers + 1;
            if ($urandom_range(0, 3) == 0) write_keep(random_keep());
            else if ($urandom_range(0, 5) == 0) wait_drained();
        end
    endtask

    task automatic test_empty_finish();
        send_request(MODE_FINISH, 32'h0, 32'sh0);
    endtask

    // The reset keep_count of ten fills up, then equal minimums and a tie with the tail are tried.
    task automatic test_default_keep();
        send_request(MODE_OFFER, 32'h0000_0000, 32'sh0000_0000);
        send_request(MODE_OFFER, 32'hffff_ffff, 32'sh7fff_ffff);
        send_request(MODE_OFFER, 32'h0000_0001, 32'sh8000_0000);
        send_request(MODE_OFFER, 32'h0000_0002, -32'sd1);
        send_request(MODE_OFFER, 32'h0000_0003, 32'sh0000_0000);
        send_request(MODE_OFFER, 32'h0000_0004, 32'sh0001_0000);
        send_request(MODE_OFFER, 32'h0000_0005, -32'sh0001_0000);
        send_request(MODE_OFFER, 32'h0000_0006, 32'sh7fff_ffff);
        send_request(MODE_OFFER, 32'h0000_0007, 32'sh0000_0005);
        send_request(MODE_OFFER, 32'h0000_0008, 32'sh8000_0000);
        send_request(MODE_OFFER, 32'h0000_0009, 32'sh8000_0000);
        send_request(MODE_OFFER, 32'h0000_000a, 32'sh8000_0001);
        send_request(MODE_FINISH, 32'hffff_ffff, 32'sh7fff_ffff);
    endtask

    task automatic test_keep_lowered();
        write_keep(3);
        send_request(MODE_OFFER, 32'd20, 32'sd100);
        send_request(MODE_OFFER, 32'd21, 32'sd200);
        send_request(MODE_OFFER, 32'd22, 32'sd300);
        write_keep(1);
        send_request(MODE_OFFER, 32'd23, 32'sd150);
        send_request(MODE_OFFER, 32'd24, 32'sd150);
        send_request(MODE_FINISH, 32'd0, 32'sd0);
    endtask

    task automatic test_keep_zero();
        write_keep(0);
        send_request(MODE_OFFER, 32'd30, 32'sd5);
        send_request(MODE_OFFER, 32'd31, 32'sd9);
        send_request(MODE_FINISH, 32'd0, 32'sd0);
    endtask

    task automatic test_streaming_no_idle();
        write_keep(KEEP_W'(MAX_KEEP));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_queries(70);
    endtask

    task automatic test_sender_idle();
        write_keep(31);
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        run_random_queries(65);
    endtask

    task automatic test_receiver_stall();
        write_keep(1);
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        run_random_queries(65);
    endtask

    task automatic test_both_idle();
        write_keep(random_keep());
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_random_queries(65);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_finish();
        test_default_keep();
        test_keep_lowered();
        test_keep_zero();
        test_streaming_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        wait_drained();
        $display("Sent %0d requests including %0d finishes and checked %0d results.",
                 request_count, finish_count, result_count);
        $display("Made %0d keep_count writes, with idle and stall phases on both channels.",
                 keep_writes);
        if (error_count == 0) begin
            $display("top_k_score_selector_unit verification clean");
        end else begin
            $display("top_k_score_selector_unit verification failed");
        end
        $finish;
    end

    initial begin
        #600000;
        $display("Run timed out.");
        $display("top_k_score_selector_unit verification failed");
        $finish;
    end

endmodule
